/* rtl/obb_pkg.sv */
// Shared types, constants and mode codes for the orthonormal basis builder.
// No dependencies; every other rtl file imports this package.
`default_nettype none

package obb_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [14:0] THRESH_RESET = 15'd164;
  localparam logic [14:0] ONE_Q14      = 15'd16384;

  // Normalizer arithmetic: 16-bit magnitudes, sum of squares, 2^28 scaling.
  localparam int MAG_W      = 16;
  localparam int SUM_W      = 34;
  localparam int NORM_SHIFT = 28;
  localparam int ROOT_STEPS = (SUM_W + NORM_SHIFT) / 2;
  localparam int QUOT_W     = 15;
  localparam int NUM_W      = MAG_W + NORM_SHIFT + 1;

  // Construction modes
  localparam logic [3:0] FUNC_U  = 4'd0;
  localparam logic [3:0] FUNC_V  = 4'd1;
  localparam logic [3:0] FUNC_W  = 4'd2;
  localparam logic [3:0] FUNC_UV = 4'd3;
  localparam logic [3:0] FUNC_VU = 4'd4;
  localparam logic [3:0] FUNC_UW = 4'd5;
  localparam logic [3:0] FUNC_WU = 4'd6;
  localparam logic [3:0] FUNC_VW = 4'd7;
  localparam logic [3:0] FUNC_WV = 4'd8;

  // Output axis slots
  localparam logic [1:0] SLOT_U = 2'd0;
  localparam logic [1:0] SLOT_V = 2'd1;
  localparam logic [1:0] SLOT_W = 2'd2;

  typedef struct packed {
    logic [3:0]         func;
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] first_z;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic signed [15:0] second_z;
  } item_t;

  typedef struct packed {
    logic signed [15:0] axis_u_x;
    logic signed [15:0] axis_u_y;
    logic signed [15:0] axis_u_z;
    logic signed [15:0] axis_v_x;
    logic signed [15:0] axis_v_y;
    logic signed [15:0] axis_v_z;
    logic signed [15:0] axis_w_x;
    logic signed [15:0] axis_w_y;
    logic signed [15:0] axis_w_z;
    logic               degenerate;
  } basis_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vec16_t;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
  } vec33_t;

  // Decoded mode: n1 = unit first vector, n2 = second unit axis, x = cross.
  typedef struct packed {
    logic       valid_mode;
    logic       perp;      // one-vector mode, n2 from perpendicular
    logic       swap_ab;   // raw cross is b x a
    logic       swap_x;    // final cross is n2 x n1
    logic [1:0] n1_slot;
    logic [1:0] n2_slot;
    logic [1:0] x_slot;
  } cls_t;

  typedef struct packed {
    cls_t   cls;
    vec16_t a;
    vec16_t b;
  } job_t;

endpackage

`default_nettype wire

/* rtl/obb_front.sv */
// Front end: input handshake and mode decode into a job for the queue.
// Depends on obb_pkg.
`default_nettype none

module obb_front import obb_pkg::*; (
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item,
  input  logic  queue_full,
  output logic  push,
  output job_t  job
);

  cls_t cls;

  always_comb begin
    cls = '0;
    cls.valid_mode = 1'b1;
    unique case (item.func)
      FUNC_U: begin
        cls.perp = 1'b1;
        cls.n1_slot = SLOT_U; cls.n2_slot = SLOT_V; cls.x_slot = SLOT_W;
      end
      FUNC_V: begin
        cls.perp = 1'b1; cls.swap_x = 1'b1;
        cls.n1_slot = SLOT_V; cls.n2_slot = SLOT_U; cls.x_slot = SLOT_W;
      end
      FUNC_W: begin
        cls.perp = 1'b1;
        cls.n1_slot = SLOT_W; cls.n2_slot = SLOT_U; cls.x_slot = SLOT_V;
      end
      FUNC_UV: begin
        cls.swap_x = 1'b1;
        cls.n1_slot = SLOT_U; cls.n2_slot = SLOT_W; cls.x_slot = SLOT_V;
      end
      FUNC_VU: begin
        cls.swap_ab = 1'b1;
        cls.n1_slot = SLOT_V; cls.n2_slot = SLOT_W; cls.x_slot = SLOT_U;
      end
      FUNC_UW: begin
        cls.swap_ab = 1'b1;
        cls.n1_slot = SLOT_U; cls.n2_slot = SLOT_V; cls.x_slot = SLOT_W;
      end
      FUNC_WU: begin
        cls.swap_x = 1'b1;
        cls.n1_slot = SLOT_W; cls.n2_slot = SLOT_V; cls.x_slot = SLOT_U;
      end
      FUNC_VW: begin
        cls.swap_x = 1'b1;
        cls.n1_slot = SLOT_V; cls.n2_slot = SLOT_U; cls.x_slot = SLOT_W;
      end
      FUNC_WV: begin
        cls.swap_ab = 1'b1;
        cls.n1_slot = SLOT_W; cls.n2_slot = SLOT_U; cls.x_slot = SLOT_V;
      end
      default: begin
        cls.valid_mode = 1'b0;
      end
    endcase
  end

  assign item_stall = queue_full;
  assign push       = item_valid && !queue_full;

  always_comb begin
    job.cls = cls;
    job.a.x = item.first_x;
    job.a.y = item.first_y;
    job.a.z = item.first_z;
    job.b.x = item.second_x;
    job.b.y = item.second_y;
    job.b.z = item.second_z;
  end

endmodule

`default_nettype wire

/* rtl/obb_queue.sv */
// Small FIFO of decoded jobs between the front end and the datapath.
// Depends on obb_pkg for the default depth QUEUE_DEPTH.
`default_nettype none

module obb_queue import obb_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH,
  parameter int Width = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [Width-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             nonempty,
  output logic [Width-1:0] head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] entries [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign full     = (count == CntW'(Depth));
  assign nonempty = (count != '0);
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/obb_norm.sv */
// Pipelined vector normalizer: squares, bit-serial square root, restoring
// divide per component. One vector per cycle while en is high. Depends on obb_pkg.
`default_nettype none

module obb_norm import obb_pkg::*; #(
  parameter int SideW = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [2:0][MAG_W-1:0]  in_mag,
  input  logic [2:0]             in_neg,
  input  logic [SideW-1:0]       in_side,
  output logic                   out_valid,
  output vec16_t                 out_vec,
  output logic                   out_zero,
  output logic [SideW-1:0]       out_side
);

  localparam int XW = SUM_W + NORM_SHIFT;

  typedef struct packed {
    logic [SUM_W-1:0]           s;
    logic [SUM_W-1:0]           rem;
    logic [ROOT_STEPS-1:0]      root;
    logic [2:0][MAG_W-1:0]      mag;
    logic [2:0]                 neg;
  } root_t;

  typedef struct packed {
    logic [2:0][NUM_W-1:0]      num;
    logic [2:0][ROOT_STEPS-1:0] r;
    logic [2:0][QUOT_W-1:0]     q;
    logic [ROOT_STEPS-1:0]      l;
    logic [2:0]                 neg;
    logic                       zero;
  } div_t;

  // squares
  logic                      s1_v;
  logic [2:0][2*MAG_W-1:0]   s1_sq;
  logic [2:0][MAG_W-1:0]     s1_mag;
  logic [2:0]                s1_neg;
  logic [SideW-1:0]          s1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_sq[i] <= in_mag[i] * in_mag[i];
      end
      s1_mag  <= in_mag;
      s1_neg  <= in_neg;
      s1_side <= in_side;
    end
  end

  // root stages; index 0 holds the sum of squares
  logic             rt_v    [0:ROOT_STEPS];
  root_t            rt      [0:ROOT_STEPS];
  logic [SideW-1:0] rt_side [0:ROOT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      rt_v[0] <= 1'b0;
    end else if (en) begin
      rt_v[0] <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rt[0].s    <= SUM_W'(s1_sq[0]) + SUM_W'(s1_sq[1]) + SUM_W'(s1_sq[2]);
      rt[0].rem  <= '0;
      rt[0].root <= '0;
      rt[0].mag  <= s1_mag;
      rt[0].neg  <= s1_neg;
      rt_side[0] <= s1_side;
    end
  end

  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
    logic [XW-1:0]    xf;
    logic [SUM_W-1:0] rem_sh;
    logic [SUM_W-1:0] trial;
    logic             ge;

    assign xf     = {rt[j].s, {NORM_SHIFT{1'b0}}};
    assign rem_sh = {rt[j].rem[SUM_W-3:0], xf[XW-1-2*j -: 2]};
    assign trial  = {1'b0, rt[j].root, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        rt_v[j+1] <= 1'b0;
      end else if (en) begin
        rt_v[j+1] <= rt_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt[j+1].s    <= rt[j].s;
        rt[j+1].mag  <= rt[j].mag;
        rt[j+1].neg  <= rt[j].neg;
        rt[j+1].rem  <= ge ? (rem_sh - trial) : rem_sh;
        rt[j+1].root <= {rt[j].root[ROOT_STEPS-2:0], ge};
        rt_side[j+1] <= rt_side[j];
      end
    end
  end

  // divide stages; index 0 holds the dividend setup
  logic             dv_v    [0:QUOT_W];
  div_t             dv      [0:QUOT_W];
  logic [SideW-1:0] dv_side [0:QUOT_W];

  logic [2:0][NUM_W-1:0] d0_num;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d0_num[i] = NUM_W'({rt[ROOT_STEPS].mag[i], {NORM_SHIFT{1'b0}}})
                + NUM_W'(rt[ROOT_STEPS].root[ROOT_STEPS-1:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= rt_v[ROOT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0].num  <= d0_num;
      for (int i = 0; i < 3; i++) begin
        dv[0].r[i] <= ROOT_STEPS'(d0_num[i][NUM_W-1:QUOT_W]);
      end
      dv[0].q    <= '0;
      dv[0].l    <= rt[ROOT_STEPS].root;
      dv[0].neg  <= rt[ROOT_STEPS].neg;
      dv[0].zero <= (rt[ROOT_STEPS].s == '0);
      dv_side[0] <= rt_side[ROOT_STEPS];
    end
  end

  for (genvar b = 0; b < QUOT_W; b++) begin : g_div
    logic [2:0][ROOT_STEPS:0] r_sh;
    logic [2:0]               ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r_sh[i] = {dv[b].r[i], dv[b].num[i][QUOT_W-1-b]};
        ge[i]   = (r_sh[i] >= {1'b0, dv[b].l});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[b+1] <= 1'b0;
      end else if (en) begin
        dv_v[b+1] <= dv_v[b];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[b+1].num  <= dv[b].num;
        dv[b+1].l    <= dv[b].l;
        dv[b+1].neg  <= dv[b].neg;
        dv[b+1].zero <= dv[b].zero;
        for (int i = 0; i < 3; i++) begin
          dv[b+1].r[i] <= ge[i] ? ROOT_STEPS'(r_sh[i] - {1'b0, dv[b].l})
                                : ROOT_STEPS'(r_sh[i]);
          dv[b+1].q[i] <= {dv[b].q[i][QUOT_W-2:0], ge[i]};
        end
        dv_side[b+1] <= dv_side[b];
      end
    end
  end

  function automatic logic signed [15:0] signed_q(logic [QUOT_W-1:0] q, logic neg,
                                                  logic zero);
    logic [15:0] p;
    p = {1'b0, q};
    if (zero) begin
      return '0;
    end
    return neg ? 16'(-p) : p;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_v[QUOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vec.x <= signed_q(dv[QUOT_W].q[0], dv[QUOT_W].neg[0], dv[QUOT_W].zero);
      out_vec.y <= signed_q(dv[QUOT_W].q[1], dv[QUOT_W].neg[1], dv[QUOT_W].zero);
      out_vec.z <= signed_q(dv[QUOT_W].q[2], dv[QUOT_W].neg[2], dv[QUOT_W].zero);
      out_zero  <= dv[QUOT_W].zero;
      out_side  <= dv_side[QUOT_W];
    end
  end

endmodule

`default_nettype wire

/* rtl/obb_back.sv */
// Datapath: raw cross, first normalize, perpendicular pick, range shift,
// second normalize, unit cross, axis placement, output register.
// Depends on obb_pkg and obb_norm.
`default_nettype none

module obb_back import obb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [14:0] threshold,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_pop,
  output logic        basis_valid,
  input  logic        basis_stall,
  output basis_t      basis
);

  localparam int Side1W = $bits(cls_t) + $bits(vec33_t);
  localparam int Side2W = $bits(cls_t) + $bits(vec16_t) + 1;

  logic adv;
  assign adv     = !basis_valid || !basis_stall;
  assign job_pop = adv && job_valid;

  function automatic logic [15:0] abs16(logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  function automatic logic [31:0] abs33(logic signed [32:0] v);
    return v[32] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [5:0] bit_len(logic [31:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 6'(i + 1);
    end
    return n;
  endfunction

  function automatic logic signed [15:0] round_q14(logic signed [32:0] d);
    logic [32:0] mag;
    logic [32:0] r;
    mag = d[32] ? 33'(-d) : 33'(d);
    r   = (mag + 33'd8192) >> 14;
    if (r > 33'(ONE_Q14)) r = 33'(ONE_Q14);
    return d[32] ? 16'(-r) : 16'(r);
  endfunction

  // ---- raw cross products
  logic               p0_v;
  cls_t               p0_cls;
  vec16_t             p0_a;
  logic signed [31:0] p0_yz, p0_zy, p0_zx, p0_xz, p0_xy, p0_yx;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_v <= 1'b0;
    end else if (adv) begin
      p0_v <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0_cls <= job.cls;
      p0_a   <= job.a;
      p0_yz  <= job.a.y * job.b.z;
      p0_zy  <= job.a.z * job.b.y;
      p0_zx  <= job.a.z * job.b.x;
      p0_xz  <= job.a.x * job.b.z;
      p0_xy  <= job.a.x * job.b.y;
      p0_yx  <= job.a.y * job.b.x;
    end
  end

  logic   p1_v;
  cls_t   p1_cls;
  vec16_t p1_a;
  vec33_t p1_c;
  vec33_t c_ab;

  always_comb begin
    c_ab.x = 33'(p0_yz) - 33'(p0_zy);
    c_ab.y = 33'(p0_zx) - 33'(p0_xz);
    c_ab.z = 33'(p0_xy) - 33'(p0_yx);
    if (p0_cls.swap_ab) begin
      c_ab.x = -c_ab.x;
      c_ab.y = -c_ab.y;
      c_ab.z = -c_ab.z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
    end else if (adv) begin
      p1_v <= p0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_cls <= p0_cls;
      p1_a   <= p0_a;
      p1_c   <= c_ab;
    end
  end

  // ---- first normalize
  logic [2:0][MAG_W-1:0] n1_in_mag;
  logic [2:0]            n1_in_neg;
  logic                  n1_v;
  vec16_t                n1_vec;
  logic                  n1_zero;
  logic [Side1W-1:0]     n1_side;
  cls_t                  n1_cls;
  vec33_t                n1_c;

  assign n1_in_mag[0] = abs16(p1_a.x);
  assign n1_in_mag[1] = abs16(p1_a.y);
  assign n1_in_mag[2] = abs16(p1_a.z);
  assign n1_in_neg    = {p1_a.z[15], p1_a.y[15], p1_a.x[15]};

  obb_norm #(.SideW(Side1W)) u_norm1 (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (p1_v),
    .in_mag    (n1_in_mag),
    .in_neg    (n1_in_neg),
    .in_side   ({p1_cls, p1_c}),
    .out_valid (n1_v),
    .out_vec   (n1_vec),
    .out_zero  (n1_zero),
    .out_side  (n1_side)
  );

  assign {n1_cls, n1_c} = n1_side;

  // ---- perpendicular test
  logic               t0_v;
  cls_t               t0_cls;
  vec33_t             t0_c;
  vec16_t             t0_n1;
  logic               t0_zero1;
  logic signed [31:0] t0_yy, t0_zz;
  logic [29:0]        t0_eps2;

  always_ff @(posedge clk) begin
    if (rst) begin
      t0_v <= 1'b0;
    end else if (adv) begin
      t0_v <= n1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t0_cls   <= n1_cls;
      t0_c     <= n1_c;
      t0_n1    <= n1_vec;
      t0_zero1 <= n1_zero;
      t0_yy    <= n1_vec.y * n1_vec.y;
      t0_zz    <= n1_vec.z * n1_vec.z;
      t0_eps2  <= threshold * threshold;
    end
  end

  logic [29:0] sum_sq;
  logic        near;
  vec33_t      c_sel;

  assign sum_sq = t0_yy[29:0] + t0_zz[29:0];
  assign near   = (sum_sq < t0_eps2);

  always_comb begin
    c_sel = t0_c;
    if (t0_cls.perp) begin
      if (near) begin
        c_sel.x = -33'(t0_n1.z);
        c_sel.y = '0;
        c_sel.z = 33'(t0_n1.x);
      end else begin
        c_sel.x = '0;
        c_sel.y = 33'(t0_n1.z);
        c_sel.z = -33'(t0_n1.y);
      end
    end
  end

  logic   t1_v;
  cls_t   t1_cls;
  vec33_t t1_c;
  vec16_t t1_n1;
  logic   t1_zero1;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_v <= 1'b0;
    end else if (adv) begin
      t1_v <= t0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_cls   <= t0_cls;
      t1_c     <= c_sel;
      t1_n1    <= t0_n1;
      t1_zero1 <= t0_zero1;
    end
  end

  // ---- range reduction to 16-bit magnitudes
  logic             k0_v, k1_v, k2_v;
  logic [2:0][31:0] k0_mag, k1_mag;
  logic [2:0]       k0_neg, k1_neg, k2_neg;
  logic [31:0]      k0_m;
  logic [4:0]       k1_k;
  logic [2:0][MAG_W-1:0] k2_mag;
  cls_t             k0_cls, k1_cls, k2_cls;
  vec16_t           k0_n1, k1_n1, k2_n1;
  logic             k0_zero1, k1_zero1, k2_zero1;

  logic [2:0][31:0] c_mag;
  logic [31:0]      c_max;
  logic [5:0]       m_len;

  always_comb begin
    c_mag[0] = abs33(t1_c.x);
    c_mag[1] = abs33(t1_c.y);
    c_mag[2] = abs33(t1_c.z);
    c_max    = c_mag[0];
    if (c_mag[1] > c_max) c_max = c_mag[1];
    if (c_mag[2] > c_max) c_max = c_mag[2];
  end

  assign m_len = bit_len(k0_m);

  always_ff @(posedge clk) begin
    if (rst) begin
      k0_v <= 1'b0;
      k1_v <= 1'b0;
      k2_v <= 1'b0;
    end else if (adv) begin
      k0_v <= t1_v;
      k1_v <= k0_v;
      k2_v <= k1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k0_mag   <= c_mag;
      k0_neg   <= {t1_c.z[32], t1_c.y[32], t1_c.x[32]};
      k0_m     <= c_max;
      k0_cls   <= t1_cls;
      k0_n1    <= t1_n1;
      k0_zero1 <= t1_zero1;

      k1_mag   <= k0_mag;
      k1_neg   <= k0_neg;
      k1_k     <= (m_len > 6'(MAG_W)) ? 5'(m_len - 6'(MAG_W)) : '0;
      k1_cls   <= k0_cls;
      k1_n1    <= k0_n1;
      k1_zero1 <= k0_zero1;

      for (int i = 0; i < 3; i++) begin
        k2_mag[i] <= MAG_W'(k1_mag[i] >> k1_k);
      end
      k2_neg   <= k1_neg;
      k2_cls   <= k1_cls;
      k2_n1    <= k1_n1;
      k2_zero1 <= k1_zero1;
    end
  end

  // ---- second normalize
  logic              n2_v;
  vec16_t            n2_vec;
  logic              n2_zero;
  logic [Side2W-1:0] n2_side;
  cls_t              n2_cls;
  vec16_t            n2_n1;
  logic              n2_zero1;

  obb_norm #(.SideW(Side2W)) u_norm2 (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (k2_v),
    .in_mag    (k2_mag),
    .in_neg    (k2_neg),
    .in_side   ({k2_cls, k2_n1, k2_zero1}),
    .out_valid (n2_v),
    .out_vec   (n2_vec),
    .out_zero  (n2_zero),
    .out_side  (n2_side)
  );

  assign {n2_cls, n2_n1, n2_zero1} = n2_side;

  // ---- unit cross
  vec16_t pa, pb;
  assign pa = n2_cls.swap_x ? n2_vec : n2_n1;
  assign pb = n2_cls.swap_x ? n2_n1 : n2_vec;

  logic               x0_v;
  cls_t               x0_cls;
  vec16_t             x0_n1, x0_n2;
  logic               x0_deg;
  logic signed [31:0] x0_yz, x0_zy, x0_zx, x0_xz, x0_xy, x0_yx;

  always_ff @(posedge clk) begin
    if (rst) begin
      x0_v <= 1'b0;
    end else if (adv) begin
      x0_v <= n2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x0_cls <= n2_cls;
      x0_n1  <= n2_n1;
      x0_n2  <= n2_vec;
      x0_deg <= n2_zero1 || n2_zero;
      x0_yz  <= pa.y * pb.z;
      x0_zy  <= pa.z * pb.y;
      x0_zx  <= pa.z * pb.x;
      x0_xz  <= pa.x * pb.z;
      x0_xy  <= pa.x * pb.y;
      x0_yx  <= pa.y * pb.x;
    end
  end

  logic   x1_v;
  cls_t   x1_cls;
  vec16_t x1_n1, x1_n2, x1_x;
  logic   x1_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      x1_v <= 1'b0;
    end else if (adv) begin
      x1_v <= x0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_cls   <= x0_cls;
      x1_n1    <= x0_n1;
      x1_n2    <= x0_n2;
      x1_deg   <= x0_deg;
      x1_x.x   <= round_q14(33'(x0_yz) - 33'(x0_zy));
      x1_x.y   <= round_q14(33'(x0_zx) - 33'(x0_xz));
      x1_x.z   <= round_q14(33'(x0_xy) - 33'(x0_yx));
    end
  end

  // ---- axis placement and output register
  function automatic vec16_t pick(logic [1:0] slot, cls_t c, vec16_t n1, vec16_t n2,
                                  vec16_t xv);
    if (!c.valid_mode) return '0;
    if (c.n1_slot == slot) return n1;
    if (c.n2_slot == slot) return n2;
    return xv;
  endfunction

  vec16_t u_ax, v_ax, w_ax;
  basis_t basis_next;

  assign u_ax = pick(SLOT_U, x1_cls, x1_n1, x1_n2, x1_x);
  assign v_ax = pick(SLOT_V, x1_cls, x1_n1, x1_n2, x1_x);
  assign w_ax = pick(SLOT_W, x1_cls, x1_n1, x1_n2, x1_x);

  always_comb begin
    basis_next.axis_u_x   = u_ax.x;
    basis_next.axis_u_y   = u_ax.y;
    basis_next.axis_u_z   = u_ax.z;
    basis_next.axis_v_x   = v_ax.x;
    basis_next.axis_v_y   = v_ax.y;
    basis_next.axis_v_z   = v_ax.z;
    basis_next.axis_w_x   = w_ax.x;
    basis_next.axis_w_y   = w_ax.y;
    basis_next.axis_w_z   = w_ax.z;
    basis_next.degenerate = x1_deg || !x1_cls.valid_mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      basis_valid <= 1'b0;
    end else if (adv) begin
      basis_valid <= x1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      basis <= basis_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/orthonormal_basis_builder.sv */
// Orthonormal basis builder top level: config register, front end, job
// queue and datapath. Depends on obb_pkg, obb_front, obb_queue, obb_back.
//
// Usage:
//  - item channel (item_valid / item_stall / item): one transaction carries
//    a mode and one or two Q3.12 vectors. It is taken whenever item_stall is
//    low; item_stall rises only when the job queue is full.
//  - basis channel (basis_valid / basis_stall / basis): one transaction per
//    item, in order, with U, V, W in Q1.14 and the degenerate flag.
//  - cfg channel (cfg_valid / cfg_ready / cfg_data): writes the near-parallel
//    threshold; cfg_ready is always high. Write only while the block is idle.
// Throughput: one item per cycle while nothing stalls. The two normalizer
//  pipelines have 31 square root steps and 15 divide steps each.
// Stall: while basis_valid is high and basis_stall is high the whole
//  datapath freezes; the queue keeps taking items until it fills.
// Reset: synchronous, active high; empties the queue and the pipeline and
//  sets the threshold to 164 (0.01 in Q1.14).
`default_nettype none

module orthonormal_basis_builder import obb_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        basis_valid,
  input  logic        basis_stall,
  output basis_t      basis
);

  localparam int JobW = $bits(job_t);

  // Near-parallel threshold, Q1.14
  logic [14:0] threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  logic            queue_full;
  logic            push;
  job_t            front_job;
  logic            pop;
  logic            head_valid;
  logic [JobW-1:0] head_bits;
  job_t            head_job;

  // Front end: handshake plus mode decode
  obb_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .queue_full (queue_full),
    .push       (push),
    .job        (front_job)
  );

  // Decouples input acceptance from datapath stalls
  obb_queue #(
    .Depth (QueueDepth),
    .Width (JobW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_job),
    .full      (queue_full),
    .pop       (pop),
    .nonempty  (head_valid),
    .head      (head_bits)
  );

  assign head_job = job_t'(head_bits);

  // Arithmetic pipeline with output register
  obb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .threshold   (threshold),
    .job_valid   (head_valid),
    .job         (head_job),
    .job_pop     (pop),
    .basis_valid (basis_valid),
    .basis_stall (basis_stall),
    .basis       (basis)
  );

endmodule

`default_nettype wire
